[src/gal_pkg.sv]
// Package with payload types and sequencer states for the GCD and LCM block.
package gal_pkg;

   typedef struct packed {
      logic [31:0] first_operand;
      logic [31:0] second_operand;
   } req_data_type;

   typedef struct packed {
      logic [31:0] divisor;
      logic [63:0] multiple;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EUCLID,
      ST_REM_WAIT,
      ST_QUO_WAIT,
      ST_MUL_WAIT,
      ST_DONE
   } seq_state_type;

endpackage

[src/gal_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module gal_div
   import gal_pkg::*;
#(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);

   localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic [W:0]       shifted;
   logic [W:0]       trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[src/gal_mul.sv]
// Shift-and-add multiplier that handles one multiplier bit per cycle.
module gal_mul
   import gal_pkg::*;
#(
   parameter int W = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   mcand,
   input  logic [W-1:0]   mplier,
   output logic           done,
   output logic [2*W-1:0] product
);

   localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [2*W-1:0]   acc_ff, acc_in;
   logic [2*W-1:0]   mcd_ff, mcd_in;
   logic [W-1:0]     mpl_ff, mpl_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mcd_in  = mcd_ff;
      mpl_in  = mpl_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         mcd_in  = (2*W)'(mcand);
         mpl_in  = mplier;
      end else if (busy_ff) begin
         if (mpl_ff[0]) begin
            acc_in = acc_ff + mcd_ff;
         end
         mcd_in = {mcd_ff[2*W-2:0], 1'b0};
         mpl_in = {1'b0, mpl_ff[W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      mcd_ff <= mcd_in;
      mpl_ff <= mpl_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[src/gcd_and_lcm_top.sv]
// Top level of the GCD and LCM block: sequencer, operand registers and result register.
// Each Euclid remainder step runs on the bit-serial divider; the final quotient of the larger
// operand by the GCD follows on the divider, then the shift-add multiply of that quotient by the
// smaller operand, then the result load. A zero operand skips the divider and the multiplier.
// One item is in work at a time; the next can be accepted in the cycle after the result loads.
// Reset clears sequencer and valid.
module gcd_and_lcm_top
   import gal_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   localparam int W = OPERAND_WIDTH;

   seq_state_type state_ff, state_in;

   logic [W-1:0]   big_ff, big_in;
   logic [W-1:0]   small_ff, small_in;
   logic [W-1:0]   orig_small_ff, orig_small_in;
   logic [W-1:0]   orig_big_ff, orig_big_in;
   logic [63:0]    lcm_ff, lcm_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_data_type   rsp_data_ff, rsp_data_in;

   logic [W-1:0]   op_x, op_y;
   logic           accept;
   logic           rsp_load;
   logic           slot_free;
   logic           div_start, div_done;
   logic [W-1:0]   div_dividend, div_divisor, div_quotient, div_remainder;
   logic           mul_start, mul_done;
   logic [2*W-1:0] mul_product;

   assign op_x      = req_data.first_operand[W-1:0];
   assign op_y      = req_data.second_operand[W-1:0];
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   gal_div #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   gal_mul #(.W(W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (div_quotient),
      .mplier  (orig_small_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EUCLID;
            end
         end
         ST_EUCLID: begin
            if (small_ff != '0) begin
               state_in = ST_REM_WAIT;
            end else if (orig_small_ff != '0) begin
               state_in = ST_QUO_WAIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_REM_WAIT: begin
            if (div_done) begin
               state_in = ST_EUCLID;
            end
         end
         ST_QUO_WAIT: begin
            if (div_done) begin
               state_in = ST_MUL_WAIT;
            end
         end
         ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      div_start    = 1'b0;
      mul_start    = 1'b0;
      rsp_load     = 1'b0;
      div_dividend = orig_big_ff;
      div_divisor  = big_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EUCLID: begin
            if (small_ff != '0) begin
               div_start    = 1'b1;
               div_dividend = big_ff;
               div_divisor  = small_ff;
            end else if (orig_small_ff != '0) begin
               div_start = 1'b1;
            end
         end
         ST_QUO_WAIT: begin
            mul_start = div_done;
         end
         ST_DONE: begin
            rsp_load = slot_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      big_in        = big_ff;
      small_in      = small_ff;
      orig_big_in   = orig_big_ff;
      orig_small_in = orig_small_ff;
      lcm_in        = lcm_ff;
      if (accept) begin
         big_in        = (op_x > op_y) ? op_x : op_y;
         small_in      = (op_x > op_y) ? op_y : op_x;
         orig_big_in   = (op_x > op_y) ? op_x : op_y;
         orig_small_in = (op_x > op_y) ? op_y : op_x;
      end
      if (state_ff == ST_REM_WAIT && div_done) begin
         big_in   = small_ff;
         small_in = div_remainder;
      end
      if (state_ff == ST_EUCLID && small_ff == '0 && orig_small_ff == '0) begin
         lcm_in = '0;
      end
      if (mul_done) begin
         lcm_in = 64'(mul_product);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.divisor  = 32'(big_ff);
         rsp_data_in.multiple = lcm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      big_ff        <= big_in;
      small_ff      <= small_in;
      orig_big_ff   <= orig_big_in;
      orig_small_ff <= orig_small_in;
      lcm_ff        <= lcm_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_div_done_state : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_REM_WAIT || state_ff == ST_QUO_WAIT))
      else $error("Divider finished outside a divide wait state.");

   a_mul_done_state : assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MUL_WAIT)
      else $error("Multiplier finished outside the multiply wait state.");

   a_zero_lcm : assert property (@(posedge clock) disable iff (reset)
      (rsp_load && orig_small_ff == '0) |-> lcm_ff == 64'd0)
      else $error("Multiple is not zero for a zero operand.");

   a_load_slot : assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("Loaded result item was not presented.");
`endif

endmodule
